[sv/csl_pkg.sv]
`default_nettype none
package csl_pkg;

  // lexer modes
  typedef enum logic [2:0] {
    M_IDLE, M_IDENT, M_NUMBER, M_LINE, M_BOPEN, M_BLOCK, M_SKIP
  } mode_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE, ST_NEXT, ST_TOK, ST_DR_RD, ST_DR_OUT, ST_OPEN, ST_EOF
  } state_t;

  // result source select
  typedef enum logic [1:0] {
    SEL_TOK, SEL_BYTE, SEL_OPEN, SEL_EOF
  } sel_t;

  typedef struct packed {
    logic step;
    logic load;
    sel_t sel;
  } cmd_t;

  typedef struct packed {
    logic tok_p;
    logic drain_p;
    logic open_p;
    logic eof_p;
    logic out_free;
    logic drain_end;
  } sts_t;

  // token codes
  localparam logic [5:0] TK_EOF   = 6'd0;
  localparam logic [5:0] TK_IDENT = 6'd1;
  localparam logic [5:0] TK_INT   = 6'd2;
  localparam logic [5:0] TK_BAD   = 6'd3;
  localparam logic [5:0] TK_OPEN  = 6'd4;
  localparam logic [5:0] TK_KW0   = 6'd5;
  localparam logic [5:0] TK_TWO0  = 6'd23;
  localparam logic [5:0] TK_ONE0  = 6'd33;

  localparam int NUM_KW  = 18;
  localparam int NUM_TWO = 10;
  localparam int NUM_ONE = 16;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SLASH = "/";
  localparam logic [7:0] CH_STAR  = "*";

  localparam logic [15:0] TWO_OPS [NUM_TWO] = '{
    "==", "!=", "<=", ">=", "&&", "||", "+=", "-=", "++", "--"
  };
  localparam logic [7:0] ONE_OPS [NUM_ONE] = '{
    "(", ")", "{", "}", ";", "-", "+", "*", "/", "=", ",", "!", "<", ">", "%", ":"
  };

  // keyword text, right aligned
  function automatic logic [63:0] kw_word(input logic [4:0] k);
    logic [63:0] w;
    unique case (k)
      5'd0:  w = 64'("int");
      5'd1:  w = 64'("char");
      5'd2:  w = 64'("short");
      5'd3:  w = 64'("long");
      5'd4:  w = 64'("return");
      5'd5:  w = 64'("if");
      5'd6:  w = 64'("else");
      5'd7:  w = 64'("while");
      5'd8:  w = 64'("for");
      5'd9:  w = 64'("break");
      5'd10: w = 64'("continue");
      5'd11: w = 64'("do");
      5'd12: w = 64'("goto");
      5'd13: w = 64'("switch");
      5'd14: w = 64'("case");
      5'd15: w = 64'("default");
      5'd16: w = 64'("_assert");
      5'd17: w = 64'("_print");
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic logic [3:0] kw_len(input logic [4:0] k);
    logic [3:0] n;
    unique case (k)
      5'd0, 5'd8:                         n = 4'd3;
      5'd1, 5'd3, 5'd6, 5'd12, 5'd14:     n = 4'd4;
      5'd2, 5'd7, 5'd9:                   n = 4'd5;
      5'd4, 5'd13, 5'd17:                 n = 4'd6;
      5'd5, 5'd11:                        n = 4'd2;
      5'd10:                              n = 4'd8;
      5'd15, 5'd16:                       n = 4'd7;
      default:                            n = 4'd0;
    endcase
    return n;
  endfunction

  // byte i of keyword k, valid for i below its length
  function automatic logic [7:0] kw_char(input logic [4:0] k, input logic [4:0] i);
    logic [63:0] w;
    logic [3:0]  p;
    w = kw_word(k);
    p = kw_len(k) - 4'd1 - i[3:0];
    return w[{p[2:0], 3'b000} +: 8];
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

endpackage
`default_nettype wire

[sv/csl_if.sv]
`default_nettype none
interface csl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_input;
  modport source (output valid, ch, end_of_input, input ready);
  modport sink   (input valid, ch, end_of_input, output ready);
endinterface

interface csl_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  token_code;
  logic [15:0] start_line;
  logic [15:0] start_col;
  logic [4:0]  length;
  logic [31:0] lit_value;
  logic [7:0]  text_byte;
  logic        text_last;
  logic        truncated;
  logic        last;
  modport source (output valid, token_code, start_line, start_col, length, lit_value,
                  text_byte, text_last, truncated, last, input ready);
  modport sink   (input valid, token_code, start_line, start_col, length, lit_value,
                  text_byte, text_last, truncated, last, output ready);
endinterface
`default_nettype wire

[sv/c_subset_lexer_top.sv]
`default_nettype none
// C subset lexer: one source byte per transfer, one byte of lookahead held.
// A result passes through ST_NEXT and ST_TOK, ST_OPEN or ST_EOF into the output register; identifier
// bytes pass through ST_DR_RD and ST_DR_OUT, as they come from the store through its registered
// read port. The input is ready again only once every result of a transfer has been loaded, so
// a stalling receiver holds the input back.
// Synchronous active-low reset clears all control state; the store needs no clearing pass.
module c_subset_lexer_top #(
  parameter int IDENT_MAX = 31,
  parameter int POS_BITS  = 16
) (
  input wire logic clk,
  input wire logic rst_n,
  csl_in_if.sink   in_s,
  csl_out_if.source out_m
);
  csl_pkg::cmd_t cmd;
  csl_pkg::sts_t sts;

  // sequencing
  csl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_s.valid),
    .in_ready (in_s.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // lexing datapath and result register
  csl_dp #(.IDENT_MAX(IDENT_MAX), .POS_BITS(POS_BITS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_ch     (in_s.ch),
    .in_eoi    (in_s.end_of_input),
    .out_ready (out_m.ready),
    .out_valid (out_m.valid),
    .out_code  (out_m.token_code),
    .out_line  (out_m.start_line),
    .out_col   (out_m.start_col),
    .out_len   (out_m.length),
    .out_val   (out_m.lit_value),
    .out_byte  (out_m.text_byte),
    .out_tlast (out_m.text_last),
    .out_trunc (out_m.truncated),
    .out_last  (out_m.last)
  );
endmodule
`default_nettype wire

[sv/csl_ram.sv]
`default_nettype none
module csl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 31
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[sv/csl_ctrl.sv]
`default_nettype none
module csl_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire csl_pkg::sts_t sts,
  output csl_pkg::cmd_t      cmd
);
  csl_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= csl_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd.step  = 1'b0;
    cmd.load  = 1'b0;
    cmd.sel   = csl_pkg::SEL_TOK;
    unique case (state_r)
      csl_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.step  = 1'b1;
          state_nxt = csl_pkg::ST_NEXT;
        end
      end
      csl_pkg::ST_NEXT: begin
        priority if (sts.tok_p)   state_nxt = csl_pkg::ST_TOK;
        else if (sts.drain_p)     state_nxt = csl_pkg::ST_DR_RD;
        else if (sts.open_p)      state_nxt = csl_pkg::ST_OPEN;
        else if (sts.eof_p)       state_nxt = csl_pkg::ST_EOF;
        else                      state_nxt = csl_pkg::ST_IDLE;
      end
      csl_pkg::ST_TOK: begin
        cmd.sel = csl_pkg::SEL_TOK;
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = csl_pkg::ST_NEXT;
        end
      end
      csl_pkg::ST_DR_RD: begin
        state_nxt = csl_pkg::ST_DR_OUT;
      end
      csl_pkg::ST_DR_OUT: begin
        cmd.sel = csl_pkg::SEL_BYTE;
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = sts.drain_end ? csl_pkg::ST_NEXT : csl_pkg::ST_DR_RD;
        end
      end
      csl_pkg::ST_OPEN: begin
        cmd.sel = csl_pkg::SEL_OPEN;
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = csl_pkg::ST_NEXT;
        end
      end
      csl_pkg::ST_EOF: begin
        cmd.sel = csl_pkg::SEL_EOF;
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = csl_pkg::ST_NEXT;
        end
      end
      default: state_nxt = csl_pkg::ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

[sv/csl_dp.sv]
`default_nettype none
module csl_dp #(
  parameter int IDENT_MAX = 31,
  parameter int POS_BITS  = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire csl_pkg::cmd_t cmd,
  output csl_pkg::sts_t      sts,
  input  wire logic [7:0]    in_ch,
  input  wire logic          in_eoi,
  input  wire logic          out_ready,
  output logic               out_valid,
  output logic [5:0]         out_code,
  output logic [15:0]        out_line,
  output logic [15:0]        out_col,
  output logic [4:0]         out_len,
  output logic [31:0]        out_val,
  output logic [7:0]         out_byte,
  output logic               out_tlast,
  output logic               out_trunc,
  output logic               out_last
);
  localparam int AW = $clog2(IDENT_MAX);
  localparam int NKW = csl_pkg::NUM_KW;
  localparam logic [POS_BITS-1:0] POS_ONE = {{(POS_BITS-1){1'b0}}, 1'b1};
  localparam logic [4:0] IMAX = 5'(IDENT_MAX);

  function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
    return (&v) ? v : v + POS_ONE;
  endfunction

  // lexer state
  csl_pkg::mode_t      mode_r, mode_nxt;
  logic [7:0]          held_r, held_nxt;
  logic                held_v_r, held_v_nxt;
  logic [4:0]          cnt_r, cnt_nxt;
  logic                ovf_r, ovf_nxt;
  logic [31:0]         acc_r, acc_nxt;
  logic [NKW-1:0]      kw_r, kw_nxt;
  logic [POS_BITS-1:0] tline_r, tline_nxt, tcol_r, tcol_nxt;
  logic [POS_BITS-1:0] cline_r, cline_nxt, ccol_r, ccol_nxt;

  // pending results of the last transfer
  logic                ptok_r, pdrain_r, popen_r, peof_r;
  logic                e_tok, e_drain, e_open;
  logic [5:0]          pcode_r, e_code;
  logic [4:0]          plen_r, e_len;
  logic [31:0]         pval_r, e_val;
  logic                dtrunc_r, e_trunc;
  logic [POS_BITS-1:0] pline_r, pcol_r, eline_r, ecol_r;
  logic [4:0]          idx_r;

  // step working values
  logic [7:0]  c, n;
  logic        hasn, do_start, add_id, add_num, kw_hit;
  logic [4:0]  base_cnt, kw_idx;
  logic        base_ovf;
  logic [31:0] base_acc;
  logic [NKW-1:0] base_kw;

  // identifier store
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_q;

  logic out_free;
  logic [31:0] wline, wcol;

  csl_ram #(.WIDTH(8), .DEPTH(IDENT_MAX)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (held_r),
    .raddr (idx_r[AW-1:0]),
    .rdata (ram_q)
  );

  // lex the held byte with the incoming byte as lookahead
  always_comb begin
    c = held_r;
    n = in_ch;
    hasn = !in_eoi;
    mode_nxt = mode_r;  held_nxt = held_r;  held_v_nxt = held_v_r;
    cnt_nxt = cnt_r;  ovf_nxt = ovf_r;  acc_nxt = acc_r;  kw_nxt = kw_r;
    tline_nxt = tline_r;  tcol_nxt = tcol_r;
    cline_nxt = cline_r;  ccol_nxt = ccol_r;
    e_tok = 1'b0;  e_drain = 1'b0;  e_open = 1'b0;
    e_code = csl_pkg::TK_EOF;  e_len = '0;  e_val = '0;  e_trunc = 1'b0;
    do_start = 1'b0;  add_id = 1'b0;  add_num = 1'b0;
    base_cnt = cnt_r;  base_ovf = ovf_r;  base_acc = acc_r;  base_kw = kw_r;
    kw_hit = 1'b0;  kw_idx = '0;
    ram_we = 1'b0;  ram_waddr = cnt_r[AW-1:0];

    if (held_v_r) begin
      unique case (mode_r)
        csl_pkg::M_SKIP:   mode_nxt = csl_pkg::M_IDLE;
        csl_pkg::M_BOPEN:  mode_nxt = csl_pkg::M_BLOCK;
        csl_pkg::M_BLOCK: begin
          if (c == csl_pkg::CH_STAR && hasn && n == csl_pkg::CH_SLASH)
            mode_nxt = csl_pkg::M_SKIP;
        end
        csl_pkg::M_LINE: begin
          if (c == csl_pkg::CH_LF) mode_nxt = csl_pkg::M_IDLE;
        end
        csl_pkg::M_IDENT:  add_id = 1'b1;
        csl_pkg::M_NUMBER: add_num = 1'b1;
        default:           do_start = 1'b1;
      endcase

      // token start
      if (do_start) begin
        mode_nxt  = csl_pkg::M_IDLE;
        tline_nxt = cline_r;
        tcol_nxt  = ccol_r;
        priority if (c == csl_pkg::CH_SLASH && hasn && n == csl_pkg::CH_SLASH) begin
          mode_nxt = csl_pkg::M_LINE;
        end else if (c == csl_pkg::CH_SLASH && hasn && n == csl_pkg::CH_STAR) begin
          mode_nxt = csl_pkg::M_BOPEN;
        end else if (csl_pkg::is_space(c)) begin
          mode_nxt = csl_pkg::M_IDLE;
        end else if (csl_pkg::is_alpha(c)) begin
          base_cnt = '0;  base_ovf = 1'b0;  base_kw = '1;
          mode_nxt = csl_pkg::M_IDENT;
          add_id = 1'b1;
        end else if (csl_pkg::is_digit(c)) begin
          base_cnt = '0;  base_acc = '0;
          mode_nxt = csl_pkg::M_NUMBER;
          add_num = 1'b1;
        end else begin
          e_tok  = 1'b1;
          e_code = csl_pkg::TK_BAD;
          for (int k = csl_pkg::NUM_ONE - 1; k >= 0; k--) begin
            if (csl_pkg::ONE_OPS[k] == c) e_code = csl_pkg::TK_ONE0 + 6'(k);
          end
          if (hasn) begin
            for (int k = csl_pkg::NUM_TWO - 1; k >= 0; k--) begin
              if (csl_pkg::TWO_OPS[k] == {c, n}) begin
                e_code   = csl_pkg::TK_TWO0 + 6'(k);
                mode_nxt = csl_pkg::M_SKIP;
              end
            end
          end
        end
      end

      // identifier byte
      if (add_id) begin
        cnt_nxt = base_cnt;  ovf_nxt = base_ovf;  kw_nxt = base_kw;
        if (base_cnt < IMAX) begin
          ram_we    = 1'b1;
          ram_waddr = base_cnt[AW-1:0];
          cnt_nxt   = base_cnt + 5'd1;
          for (int k = 0; k < NKW; k++) begin
            kw_nxt[k] = base_kw[k] && (base_cnt < 5'(csl_pkg::kw_len(5'(k)))) &&
                        (csl_pkg::kw_char(5'(k), base_cnt) == c);
          end
        end else begin
          ovf_nxt = 1'b1;
        end
        if (!(hasn && (csl_pkg::is_alpha(n) || csl_pkg::is_digit(n)))) begin
          for (int k = 0; k < NKW; k++) begin
            if (kw_nxt[k] && cnt_nxt == 5'(csl_pkg::kw_len(5'(k)))) begin
              kw_hit = 1'b1;
              kw_idx = 5'(k);
            end
          end
          if (kw_hit && !ovf_nxt) begin
            e_tok  = 1'b1;
            e_code = csl_pkg::TK_KW0 + {1'b0, kw_idx};
          end else begin
            e_drain = 1'b1;
            e_len   = cnt_nxt;
            e_trunc = ovf_nxt;
            ovf_nxt = 1'b0;
          end
          cnt_nxt  = '0;
          mode_nxt = csl_pkg::M_IDLE;
        end
      end

      // literal digit
      if (add_num) begin
        acc_nxt = (base_acc << 3) + (base_acc << 1) + {24'd0, c - "0"};
        cnt_nxt = (base_cnt != 5'd31) ? base_cnt + 5'd1 : base_cnt;
        if (!(hasn && csl_pkg::is_digit(n))) begin
          e_tok    = 1'b1;
          e_code   = csl_pkg::TK_INT;
          e_len    = cnt_nxt;
          e_val    = acc_nxt;
          cnt_nxt  = '0;
          acc_nxt  = '0;
          mode_nxt = csl_pkg::M_IDLE;
        end
      end

      // position of the next byte
      if (c == csl_pkg::CH_LF) begin
        cline_nxt = sat_inc(cline_r);
        ccol_nxt  = POS_ONE;
      end else begin
        ccol_nxt = sat_inc(ccol_r);
      end
    end

    e_open = in_eoi && (mode_nxt == csl_pkg::M_BOPEN || mode_nxt == csl_pkg::M_BLOCK);
    if (!in_eoi) begin
      held_nxt   = in_ch;
      held_v_nxt = 1'b1;
    end
    ram_we = ram_we && cmd.step;
  end

  // lexer state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= csl_pkg::M_IDLE;  held_r <= '0;  held_v_r <= 1'b0;
      cnt_r <= '0;  ovf_r <= 1'b0;  acc_r <= '0;  kw_r <= '0;
      tline_r <= POS_ONE;  tcol_r <= POS_ONE;
      cline_r <= POS_ONE;  ccol_r <= POS_ONE;
    end else if (cmd.step) begin
      kw_r <= kw_nxt;
      if (in_eoi) begin
        mode_r <= csl_pkg::M_IDLE;  held_r <= '0;  held_v_r <= 1'b0;
        cnt_r <= '0;  ovf_r <= 1'b0;  acc_r <= '0;
        tline_r <= POS_ONE;  tcol_r <= POS_ONE;
        cline_r <= POS_ONE;  ccol_r <= POS_ONE;
      end else begin
        mode_r <= mode_nxt;  held_r <= held_nxt;  held_v_r <= held_v_nxt;
        cnt_r <= cnt_nxt;  ovf_r <= ovf_nxt;  acc_r <= acc_nxt;
        tline_r <= tline_nxt;  tcol_r <= tcol_nxt;
        cline_r <= cline_nxt;  ccol_r <= ccol_nxt;
      end
    end
  end

  // pending flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptok_r <= 1'b0;  pdrain_r <= 1'b0;  popen_r <= 1'b0;  peof_r <= 1'b0;
      idx_r <= '0;
    end else if (cmd.step) begin
      ptok_r <= e_tok;  pdrain_r <= e_drain;  popen_r <= e_open;  peof_r <= in_eoi;
      idx_r <= '0;
    end else if (cmd.load) begin
      unique case (cmd.sel)
        csl_pkg::SEL_TOK:  ptok_r <= 1'b0;
        csl_pkg::SEL_BYTE: begin
          idx_r <= idx_r + 5'd1;
          if (sts.drain_end) pdrain_r <= 1'b0;
        end
        csl_pkg::SEL_OPEN: popen_r <= 1'b0;
        csl_pkg::SEL_EOF:  peof_r <= 1'b0;
        default: ;
      endcase
    end
  end

  // pending payload
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      pcode_r  <= e_code;  plen_r <= e_len;  pval_r <= e_val;  dtrunc_r <= e_trunc;
      pline_r  <= tline_nxt;  pcol_r <= tcol_nxt;
      eline_r  <= cline_nxt;  ecol_r <= ccol_nxt;
    end
  end

  assign out_free = !out_valid || out_ready;

  always_comb begin
    sts.tok_p     = ptok_r;
    sts.drain_p   = pdrain_r;
    sts.open_p    = popen_r;
    sts.eof_p     = peof_r;
    sts.out_free  = out_free;
    sts.drain_end = (idx_r + 5'd1) == plen_r;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign wline = 32'(pline_r);
  assign wcol  = 32'(pcol_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_line  <= wline[15:0];
      out_col   <= wcol[15:0];
      out_len   <= '0;
      out_val   <= '0;
      out_byte  <= '0;
      out_tlast <= 1'b1;
      out_trunc <= 1'b0;
      unique case (cmd.sel)
        csl_pkg::SEL_TOK: begin
          out_code <= pcode_r;
          out_len  <= plen_r;
          out_val  <= pval_r;
          out_last <= !popen_r && !peof_r;
        end
        csl_pkg::SEL_BYTE: begin
          out_code  <= csl_pkg::TK_IDENT;
          out_len   <= plen_r;
          out_byte  <= ram_q;
          out_tlast <= sts.drain_end;
          out_trunc <= dtrunc_r;
          out_last  <= sts.drain_end && !popen_r && !peof_r;
        end
        csl_pkg::SEL_OPEN: begin
          out_code <= csl_pkg::TK_OPEN;
          out_last <= !peof_r;
        end
        csl_pkg::SEL_EOF: begin
          out_code <= csl_pkg::TK_EOF;
          out_line <= 16'(32'(eline_r));
          out_col  <= 16'(32'(ecol_r));
          out_last <= 1'b1;
        end
        default: out_code <= csl_pkg::TK_EOF;
      endcase
    end
  end
endmodule
`default_nettype wire

[sim/tb_c_subset_lexer_top.sv]
module tb_c_subset_lexer_top;

  localparam int         WATCHDOG_MAX   = 20000;
  localparam int         TAIL_CYCLES    = 80;

  // lexer modes of the predictor
  typedef enum int { LM_IDLE, LM_IDENT, LM_NUMBER, LM_LINE, LM_BOPEN, LM_BLOCK,
                     LM_SKIP } lex_mode_t;

  typedef struct {
    logic [5:0]  code;
    logic [15:0] line;
    logic [15:0] col;
    logic [4:0]  len;
    logic [31:0] val;
    logic [7:0]  tbyte;
    logic        tlast;
    logic        trunc;
    logic        lst;
  } token_t;

  // directed stimulus row: byte, end flag, optional typed expectation
  typedef struct {
    logic [7:0] ch;
    logic       eoi;
    logic       has_exp;
    logic [5:0] exp_code;
    logic [15:0] exp_line;
    logic [15:0] exp_col;
  } dir_row_t;

  logic clk;
  logic rst_n;
  csl_in_if  in_c ();
  csl_out_if out_c ();

  c_subset_lexer_top i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_c.sink),
    .out_m (out_c.source)
  );

  // predictor state
  lex_mode_t   lx_mode;
  logic [7:0]  lx_held;
  logic        lx_held_v;
  logic [7:0]  lx_store [31];
  int          lx_count;
  logic        lx_ovf;
  logic [31:0] lx_accum;
  logic [15:0] lx_tline, lx_tcol, lx_cline, lx_ccol;

  token_t expected_tokens [$];
  token_t step_tokens [$];
  int     errors;
  int     n_in, n_out, n_ident, n_kw, n_open;
  int     idle_cycles;
  bit     hold_off_req;

  string kw_names [18] = '{"int", "char", "short", "long", "return", "if", "else",
    "while", "for", "break", "continue", "do", "goto", "switch", "case", "default",
    "_assert", "_print"};
  string two_names [10] = '{"==", "!=", "<=", ">=", "&&", "||", "+=", "-=", "++", "--"};
  string one_names = "(){};-+*/=,!<>%:";

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit is_dig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic bit is_alp(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction
  function automatic bit is_idc(logic [7:0] c);
    return is_alp(c) || is_dig(c);
  endfunction
  function automatic bit is_ws(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  task automatic emit(logic [5:0] code, logic [15:0] line, logic [15:0] col,
                      logic [4:0] len, logic [31:0] val, logic [7:0] tb,
                      logic tl, logic tr);
    token_t t;
    t.code = code; t.line = line; t.col = col; t.len = len; t.val = val;
    t.tbyte = tb; t.tlast = tl; t.trunc = tr; t.lst = 1'b0;
    step_tokens.push_back(t);
  endtask

  task automatic pos_reset();
    lx_mode = LM_IDLE; lx_held = 8'd0; lx_held_v = 1'b0; lx_count = 0;
    lx_ovf = 1'b0; lx_accum = '0;
    lx_tline = 16'd1; lx_tcol = 16'd1; lx_cline = 16'd1; lx_ccol = 16'd1;
  endtask

  task automatic ident_push(logic [7:0] c);
    if (lx_count < 31) begin
      lx_store[lx_count] = c;
      lx_count++;
    end else begin
      lx_ovf = 1'b1;
    end
  endtask

  task automatic ident_close();
    bit hit;
    int k, i;
    if (!lx_ovf) begin
      for (k = 0; k < 18; k++) begin
        if (kw_names[k].len() == lx_count) begin
          hit = 1;
          for (i = 0; i < lx_count; i++)
            if (kw_names[k][i] != lx_store[i]) hit = 0;
          if (hit) begin
            emit(csl_pkg::TK_KW0 + 6'(k), lx_tline, lx_tcol, 5'd0, 32'd0, 8'd0,
                 1'b1, 1'b0);
            n_kw++;
            lx_mode = LM_IDLE; lx_count = 0;
            return;
          end
        end
      end
    end
    for (i = 0; i < lx_count; i++)
      emit(csl_pkg::TK_IDENT, lx_tline, lx_tcol, 5'(lx_count), 32'd0, lx_store[i],
           i + 1 == lx_count, lx_ovf);
    n_ident++;
    lx_mode = LM_IDLE; lx_count = 0; lx_ovf = 1'b0;
  endtask

  task automatic digit_push(logic [7:0] c);
    lx_accum = lx_accum * 32'd10 + 32'(c - "0");
    if (lx_count < 31) lx_count++;
  endtask

  task automatic number_close();
    emit(csl_pkg::TK_INT, lx_tline, lx_tcol, 5'(lx_count), lx_accum, 8'd0, 1'b1, 1'b0);
    lx_mode = LM_IDLE; lx_count = 0; lx_accum = '0;
  endtask

  task automatic token_begin(logic [7:0] c, logic [7:0] n, bit hasn);
    int k;
    lx_tline = lx_cline; lx_tcol = lx_ccol;
    if (c == "/" && hasn && n == "/") begin lx_mode = LM_LINE; return; end
    if (c == "/" && hasn && n == "*") begin lx_mode = LM_BOPEN; return; end
    if (is_ws(c)) return;
    if (is_alp(c)) begin
      lx_count = 0; lx_ovf = 1'b0; lx_mode = LM_IDENT;
      ident_push(c);
      if (!(hasn && is_idc(n))) ident_close();
      return;
    end
    if (is_dig(c)) begin
      lx_count = 0; lx_accum = '0; lx_mode = LM_NUMBER;
      digit_push(c);
      if (!(hasn && is_dig(n))) number_close();
      return;
    end
    if (hasn) begin
      for (k = 0; k < 10; k++) begin
        if (two_names[k][0] == c && two_names[k][1] == n) begin
          emit(csl_pkg::TK_TWO0 + 6'(k), lx_tline, lx_tcol, 5'd0, 32'd0, 8'd0,
               1'b1, 1'b0);
          lx_mode = LM_SKIP;
          return;
        end
      end
    end
    for (k = 0; k < 16; k++) begin
      if (one_names[k] == c) begin
        emit(csl_pkg::TK_ONE0 + 6'(k), lx_tline, lx_tcol, 5'd0, 32'd0, 8'd0,
             1'b1, 1'b0);
        return;
      end
    end
    emit(csl_pkg::TK_BAD, lx_tline, lx_tcol, 5'd0, 32'd0, 8'd0, 1'b1, 1'b0);
  endtask

  task automatic held_byte_lex(logic [7:0] c, logic [7:0] n, bit hasn);
    case (lx_mode)
      LM_SKIP:   lx_mode = LM_IDLE;
      LM_BOPEN:  lx_mode = LM_BLOCK;
      LM_BLOCK:  if (c == "*" && hasn && n == "/") lx_mode = LM_SKIP;
      LM_LINE:   if (c == csl_pkg::CH_LF) lx_mode = LM_IDLE;
      LM_IDENT: begin
        ident_push(c);
        if (!(hasn && is_idc(n))) ident_close();
      end
      LM_NUMBER: begin
        digit_push(c);
        if (!(hasn && is_dig(n))) number_close();
      end
      default: begin
        lx_mode = LM_IDLE;
        token_begin(c, n, hasn);
      end
    endcase
    if (c == csl_pkg::CH_LF) begin
      if (lx_cline != 16'hFFFF) lx_cline++;
      lx_ccol = 16'd1;
    end else if (lx_ccol != 16'hFFFF) begin
      lx_ccol++;
    end
  endtask

  // predict all tokens caused by one accepted input transfer
  task automatic predict_tokens(logic [7:0] ch, logic eoi);
    step_tokens.delete();
    if (lx_held_v) held_byte_lex(lx_held, ch, !eoi);
    if (eoi) begin
      if (lx_mode == LM_BOPEN || lx_mode == LM_BLOCK) begin
        emit(csl_pkg::TK_OPEN, lx_tline, lx_tcol, 5'd0, 32'd0, 8'd0, 1'b1, 1'b0);
        n_open++;
      end
      emit(csl_pkg::TK_EOF, lx_cline, lx_ccol, 5'd0, 32'd0, 8'd0, 1'b1, 1'b0);
      pos_reset();
    end else begin
      lx_held = ch; lx_held_v = 1'b1;
    end
    if (step_tokens.size() > 0) step_tokens[$].lst = 1'b1;
    foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
  endtask

  // input driver; valid stays high across back-to-back transfers
  task automatic send_byte(logic [7:0] ch, logic eoi);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_c.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_c.valid <= 1'b1;
    in_c.ch <= eoi ? 8'($urandom) : ch;
    in_c.end_of_input <= eoi;
    @(posedge clk);
    while (!in_c.ready) @(posedge clk);
    predict_tokens(in_c.ch, eoi);
    n_in++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  // random fragment: mostly well-formed C, some noise
  task automatic send_fragment();
    string s;
    int n;
    case ($urandom_range(0, 11))
      0: s = kw_names[$urandom_range(0, 17)];
      1: begin
        n = $urandom_range(1, 6);
        s = "";
        for (int i = 0; i < n; i++) s = {s, string'(byte'(i == 0 ? "a" + $urandom_range(0, 25)
              : "0" + $urandom_range(0, 9)))};
      end
      2: s = $sformatf("%0d", $urandom);
      3: s = two_names[$urandom_range(0, 9)];
      4: s = string'(byte'(one_names[$urandom_range(0, 15)]));
      5: s = "// note\n";
      6: s = "/* x * / */";
      7: s = ($urandom_range(0, 1)) ? "\n" : "\t ";
      8: s = "x_Q9 = y+1;";
      9: s = "if(a<=b){c--;}";
      default: s = "";
    endcase
    if (s.len() == 0) send_byte(8'($urandom), 1'b0);
    else send_text(s);
    if ($urandom_range(0, 2) == 0) send_byte(" ", 1'b0);
  endtask

  // output sink with random stalls and one long hold-off
  initial begin
    int stall;
    out_c.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_c.ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_off_req = 0;
      end
      stall = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0) begin
        out_c.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_c.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // result checker
  always @(posedge clk) begin
    token_t e;
    if (rst_n && out_c.valid && out_c.ready) begin
      n_out++;
      if (expected_tokens.size() == 0) begin
        errors++;
        $display("%0t: unexpected token code %0d", $time, out_c.token_code);
      end else begin
        e = expected_tokens.pop_front();
        if (out_c.token_code !== e.code || out_c.start_line !== e.line ||
            out_c.start_col !== e.col || out_c.length !== e.len ||
            out_c.lit_value !== e.val || out_c.text_byte !== e.tbyte ||
            out_c.text_last !== e.tlast || out_c.truncated !== e.trunc ||
            out_c.last !== e.lst) begin
          errors++;
          $display("%0t: mismatch exp code=%0d l=%0d c=%0d len=%0d v=%0d b=%h tl=%b tr=%b last=%b",
                   $time, e.code, e.line, e.col, e.len, e.val, e.tbyte, e.tlast, e.trunc,
                   e.lst);
          $display("%0t:          act code=%0d l=%0d c=%0d len=%0d v=%0d b=%h tl=%b tr=%b last=%b",
                   $time, out_c.token_code, out_c.start_line, out_c.start_col,
                   out_c.length, out_c.lit_value, out_c.text_byte, out_c.text_last,
                   out_c.truncated, out_c.last);
        end
      end
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if ((in_c.valid && in_c.ready) || (out_c.valid && out_c.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_MAX) begin
      $display("%0t: watchdog expired, %0d tokens outstanding", $time,
               expected_tokens.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // stimulus
  initial begin
    dir_row_t rows [$];
    dir_row_t r;
    string    dtext;
    errors = 0; n_in = 0; n_out = 0; n_ident = 0; n_kw = 0; n_open = 0;
    idle_cycles = 0; hold_off_req = 0;
    in_c.valid = 1'b0; in_c.ch = 8'd0; in_c.end_of_input = 1'b0;
    rst_n = 1'b0;
    pos_reset();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty source, then bad bytes 0 and 255, then an open comment
    r = '{8'd0, 1'b1, 1'b1, csl_pkg::TK_EOF, 16'd1, 16'd1}; rows.push_back(r);
    r = '{8'h00, 1'b0, 1'b0, 0, 0, 0}; rows.push_back(r);
    r = '{8'hFF, 1'b0, 1'b1, csl_pkg::TK_BAD, 16'd1, 16'd1}; rows.push_back(r);
    r = '{8'd0, 1'b1, 1'b1, csl_pkg::TK_BAD, 16'd1, 16'd2}; rows.push_back(r);
    dtext = "/*/";
    foreach (dtext[i]) begin r = '{dtext[i], 1'b0, 1'b0, 0, 0, 0}; rows.push_back(r); end
    r = '{8'd0, 1'b1, 1'b1, csl_pkg::TK_OPEN, 16'd1, 16'd1}; rows.push_back(r);
    // keywords and operators; checked by the predictor
    dtext = "continue _assert _print&&||+=--%";
    foreach (dtext[i]) begin r = '{dtext[i], 1'b0, 1'b0, 0, 0, 0}; rows.push_back(r); end
    r = '{8'd0, 1'b1, 1'b0, 0, 0, 0}; rows.push_back(r);

    for (int i = 0; i < rows.size(); i++) begin
      send_byte(rows[i].ch, rows[i].eoi);
      if (rows[i].has_exp) begin
        if (step_tokens.size() == 0 || step_tokens[0].code !== rows[i].exp_code ||
            step_tokens[0].line !== rows[i].exp_line ||
            step_tokens[0].col !== rows[i].exp_col) begin
          errors++;
          $display("%0t: directed row %0d exp code=%0d l=%0d c=%0d act code=%0d", $time, i,
                   rows[i].exp_code, rows[i].exp_line, rows[i].exp_col,
                   step_tokens.size() ? step_tokens[0].code : 6'h3F);
        end
      end
    end

    // long identifier and long literal
    send_text("abcdefghijklmnopqrstuvwxyzABCDEFGHIJ 12345678901234567890123456789012345 ");
    send_byte(8'd0, 1'b1);

    // long receiver hold-off while the sender keeps offering
    hold_off_req = 1;
    send_text("a1 b22 c333 d4444 e5 while(x) ");

    // random part
    while (n_in < 150) begin
      send_fragment();
      if ($urandom_range(0, 40) == 0) send_byte(8'd0, 1'b1);
    end
    send_text("/* unterminated");
    send_byte(8'd0, 1'b1);
    in_c.valid <= 1'b0;

    while (expected_tokens.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d input transfers, %0d tokens: %0d identifiers, %0d keywords,",
             n_in, n_out, n_ident, n_kw);
    $display("%0d open comments, bad bytes, wrapping literals and a long output stall",
             n_open);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
